### rtl/core/tlvd_pkg.sv
// Shared types and codes for the TLV datagram deframer.
// Depends on nothing; every other file of the block imports it.
package tlvd_pkg;

    localparam int unsigned HDR_BYTES     = 4;
    localparam int unsigned REC_HDR_BYTES = 2;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_TYPE   = 3'd1,
        PH_LEN    = 3'd2,
        PH_BODY   = 3'd3,
        PH_DROP   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        EV_START = 2'd0,
        EV_BODY  = 2'd1,
        EV_ERROR = 2'd2
    } event_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_SHORT   = 3'd1,
        ST_BAD_MAGIC   = 3'd2,
        ST_BAD_VERSION = 3'd3,
        ST_BAD_LENGTH  = 3'd4,
        ST_TRUNCATED   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        REG_MAGIC   = 2'd0,
        REG_VERSION = 2'd1,
        REG_PAD_ONE = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [7:0] magic_value;
        logic [7:0] version_value;
        logic [7:0] pad_one_code;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_of_datagram;
        logic [15:0] total_length;
    } item_t;

    typedef struct packed {
        event_t      event_res;
        status_t     status;
        logic [7:0]  record_type;
        logic [7:0]  record_length;
        logic [7:0]  body_byte;
        logic [15:0] record_offset;
        logic        last_of_record;
    } result_t;

endpackage

### rtl/core/tlvd_cfg_regs.sv
// Configuration register file of the TLV datagram deframer.
// Depends on tlvd_pkg for the register index codes and the cfg_t struct.
module tlvd_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic [1:0]       cfg_index,
    input  logic [7:0]       cfg_data,
    output logic             cfg_ready,
    output tlvd_pkg::cfg_t   cfg
);
    import tlvd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // The register file can take a write in every cycle.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MAGIC:   cfg_next.magic_value   = cfg_data;
                REG_VERSION: cfg_next.version_value = cfg_data;
                REG_PAD_ONE: cfg_next.pad_one_code  = cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/core/tlvd_parser.sv
// Parse state and per-byte decision logic of the TLV datagram deframer.
// Depends on tlvd_pkg for the phase, event and status codes and the structs.
module tlvd_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  tlvd_pkg::item_t    item,
    input  tlvd_pkg::cfg_t     cfg,
    output logic               has_result,
    output tlvd_pkg::result_t  result
);
    import tlvd_pkg::*;

    phase_t      phase_reg,         phase_next;
    logic [15:0] byte_position_reg, byte_position_next;
    logic [7:0]  length_high_reg,   length_high_next;
    logic [15:0] record_start_reg,  record_start_next;
    logic [7:0]  current_type_reg,  current_type_next;
    logic [7:0]  current_length_reg, current_length_next;
    logic [7:0]  body_remaining_reg, body_remaining_next;

    phase_t      phase_eff;
    logic [15:0] pos;
    logic [7:0]  length_high_eff;
    logic [7:0]  data;
    logic [15:0] tl;
    logic        past_end;
    logic        lone_type;
    logic        body_len_ok;
    logic [16:0] room;
    logic [8:0]  need;
    logic        rec_truncated;
    logic [7:0]  remaining_dec;

    assign data = item.data_byte;
    assign tl   = item.total_length;

    always_comb
    begin
        // A first flag restarts the parse before this byte is looked at.
        phase_eff       = item.first_of_datagram ? PH_HEADER : phase_reg;
        pos             = item.first_of_datagram ? 16'd0 : byte_position_reg;
        length_high_eff = item.first_of_datagram ? 8'd0 : length_high_reg;

        past_end    = pos >= tl;
        lone_type   = ({1'b0, pos} + 17'd1) >= {1'b0, tl};
        body_len_ok = ({1'b0, length_high_eff, data} + 17'(HDR_BYTES)) == {1'b0, tl};

        // Bytes left from the record's type byte to the end of the datagram;
        // a borrow means the record already lies past the end, never short.
        room          = {1'b0, tl} - {1'b0, record_start_reg};
        need          = {1'b0, data} + 9'(REC_HDR_BYTES);
        rec_truncated = !room[16] && (room[15:0] < {7'd0, need});

        remaining_dec = (body_remaining_reg != 8'd0) ? body_remaining_reg - 8'd1 : 8'd0;

        phase_next          = phase_eff;
        byte_position_next  = (pos == 16'hFFFF) ? pos : pos + 16'd1;
        length_high_next    = length_high_eff;
        record_start_next   = record_start_reg;
        current_type_next   = current_type_reg;
        current_length_next = current_length_reg;
        body_remaining_next = body_remaining_reg;

        has_result = 1'b0;
        result     = '{event_res: EV_ERROR, status: ST_OK, record_type: 8'd0,
                       record_length: 8'd0, body_byte: 8'd0, record_offset: 16'd0,
                       last_of_record: 1'b0};

        unique case (phase_eff)
            PH_HEADER:
            begin
                if (pos == 16'd0)
                begin
                    if (tl < 16'(HDR_BYTES))
                    begin
                        has_result    = 1'b1;
                        result.status = ST_TOO_SHORT;
                        phase_next    = PH_DROP;
                    end
                    else if (data != cfg.magic_value)
                    begin
                        has_result    = 1'b1;
                        result.status = ST_BAD_MAGIC;
                        phase_next    = PH_DROP;
                    end
                end
                else if (pos == 16'd1)
                begin
                    if (data != cfg.version_value)
                    begin
                        has_result    = 1'b1;
                        result.status = ST_BAD_VERSION;
                        phase_next    = PH_DROP;
                    end
                end
                else if (pos == 16'd2)
                begin
                    length_high_next = data;
                end
                else if (pos == 16'd3)
                begin
                    if (!body_len_ok)
                    begin
                        has_result    = 1'b1;
                        result.status = ST_BAD_LENGTH;
                        phase_next    = PH_DROP;
                    end
                    else
                    begin
                        phase_next = PH_TYPE;
                    end
                end
            end

            PH_TYPE:
            begin
                if (!past_end)
                begin
                    record_start_next    = pos;
                    current_type_next    = data;
                    result.record_type   = data;
                    result.record_offset = pos;
                    if (data == cfg.pad_one_code)
                    begin
                        current_length_next   = 8'd0;
                        has_result            = 1'b1;
                        result.event_res      = EV_START;
                        result.last_of_record = 1'b1;
                    end
                    else if (lone_type)
                    begin
                        current_length_next = 8'd0;
                        has_result          = 1'b1;
                        result.status       = ST_TRUNCATED;
                        phase_next          = PH_DROP;
                    end
                    else
                    begin
                        phase_next = PH_LEN;
                    end
                end
            end

            PH_LEN:
            begin
                if (!past_end)
                begin
                    current_length_next  = data;
                    has_result           = 1'b1;
                    result.record_type   = current_type_reg;
                    result.record_length = data;
                    result.record_offset = record_start_reg;
                    if (rec_truncated)
                    begin
                        result.status = ST_TRUNCATED;
                        phase_next    = PH_DROP;
                    end
                    else if (data == 8'd0)
                    begin
                        result.event_res      = EV_START;
                        result.last_of_record = 1'b1;
                        phase_next            = PH_TYPE;
                    end
                    else
                    begin
                        result.event_res    = EV_START;
                        body_remaining_next = data;
                        phase_next          = PH_BODY;
                    end
                end
            end

            PH_BODY:
            begin
                if (!past_end)
                begin
                    body_remaining_next   = remaining_dec;
                    has_result            = 1'b1;
                    result.event_res      = EV_BODY;
                    result.record_type    = current_type_reg;
                    result.record_length  = current_length_reg;
                    result.body_byte      = data;
                    result.record_offset  = record_start_reg;
                    result.last_of_record = (remaining_dec == 8'd0);
                    if (remaining_dec == 8'd0)
                    begin
                        phase_next = PH_TYPE;
                    end
                end
            end

            PH_DROP:
            begin
                has_result = 1'b0;
            end

            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HEADER;
            byte_position_reg  <= '0;
            length_high_reg    <= '0;
            record_start_reg   <= '0;
            current_type_reg   <= '0;
            current_length_reg <= '0;
            body_remaining_reg <= '0;
        end
        else if (take)
        begin
            phase_reg          <= phase_next;
            byte_position_reg  <= byte_position_next;
            length_high_reg    <= length_high_next;
            record_start_reg   <= record_start_next;
            current_type_reg   <= current_type_next;
            current_length_reg <= current_length_next;
            body_remaining_reg <= body_remaining_next;
        end
    end

    // Any error ends the datagram.
    assert property (@(posedge clk) disable iff (!rst_n)
        take && has_result && (result.event_res == EV_ERROR) |=> phase_reg == PH_DROP)
        else $error("error result did not drop the datagram");

    // A dropped datagram stays silent until the next first flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        take && (phase_reg == PH_DROP) && !item.first_of_datagram |-> !has_result)
        else $error("result produced for a dropped datagram");

    // The last body byte of a record returns the parse to the next type byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        take && has_result && (result.event_res == EV_BODY) && result.last_of_record
        |=> phase_reg == PH_TYPE)
        else $error("parse did not return to type phase after last body byte");

endmodule

### rtl/core/tlv_datagram_deframer.sv
// Top level of the TLV datagram deframer: input register, parser, result register.
// Depends on tlvd_pkg, tlvd_cfg_regs and tlvd_parser.
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+-----------------------------------------------
//  item     | item_valid / item_stall   | data_byte, first_of_datagram, total_length
//  result   | result_valid / result_stall| event_res, status, record_type, record_length,
//           |                           | body_byte, record_offset, last_of_record
//  config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One byte is taken per cycle unless a stalled result holds the parser.
// A byte is parsed from the input register; its result, if any, is registered.
// Throughput is set by the single parser step between the input register and
// the result register; a byte that gives no result still passes through that step.
// Reset (rst_n low) clears the parse state, the configuration registers and
// both valid flags. A stalled result holds the parser; the input register then
// fills and item_stall rises, so at most one byte waits inside the block.
module tlv_datagram_deframer (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_of_datagram,
    input  logic [15:0] total_length,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  event_res,
    output logic [2:0]  status,
    output logic [7:0]  record_type,
    output logic [7:0]  record_length,
    output logic [7:0]  body_byte,
    output logic [15:0] record_offset,
    output logic        last_of_record,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import tlvd_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result_reg;
    logic    result_valid_reg;
    logic    take;
    logic    has_result;
    result_t result;

    tlvd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    // The held byte moves through the parser whenever the result register is
    // empty or is handing its content over in this same cycle.
    assign take       = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            item_valid_reg <= item_valid;
        end
    end

    // Payload register; loaded on every transfer into the input stage.
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg.data_byte         <= data_byte;
            item_reg.first_of_datagram <= first_of_datagram;
            item_reg.total_length      <= total_length;
        end
    end

    tlvd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .item       (item_reg),
        .cfg        (cfg),
        .has_result (has_result),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            result_valid_reg <= has_result;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && has_result)
        begin
            result_reg <= result;
        end
    end

    assign result_valid   = result_valid_reg;
    assign event_res      = result_reg.event_res;
    assign status         = result_reg.status;
    assign record_type    = result_reg.record_type;
    assign record_length  = result_reg.record_length;
    assign body_byte      = result_reg.body_byte;
    assign record_offset  = result_reg.record_offset;
    assign last_of_record = result_reg.last_of_record;

endmodule
